// File: hw/rtl/gbr_pkg.sv
package gbr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 4;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int LOW_W       = $clog2(MAX_WIDTH);

  localparam int PIX_W    = 8;
  localparam int RGB_W    = 3 * PIX_W;
  localparam int WEIGHT_W = 18;
  localparam int CFG_W    = 18;
  localparam int IDX_W    = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_WEIGHT_0 = 3'd3;

  localparam logic [2:0]  RADIUS_RST = 3'd1;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [WEIGHT_W-1:0] WEIGHT0_RST = 18'd78643;
  localparam logic [WEIGHT_W-1:0] WEIGHT1_RST = 18'd874;

  // floor(v / 9) for v < 4096 is (v * 7282) >> 16
  localparam logic [12:0] RECIP9 = 13'd7282;

  localparam int KIND_PIXEL = 0;

endpackage

// File: hw/rtl/gbr_in_if.sv
interface gbr_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [gbr_pkg::PIX_W-1:0] pixel_red;
  logic [gbr_pkg::PIX_W-1:0] pixel_green;
  logic [gbr_pkg::PIX_W-1:0] pixel_blue;

  modport source (output valid, kind, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink (input valid, kind, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

// File: hw/rtl/gbr_out_if.sv
interface gbr_out_if;
  logic valid;
  logic ready;
  logic [gbr_pkg::PIX_W-1:0] blur_red;
  logic [gbr_pkg::PIX_W-1:0] blur_green;
  logic [gbr_pkg::PIX_W-1:0] blur_blue;
  logic frame_end;

  modport source (output valid, blur_red, blur_green, blur_blue, frame_end, input ready);
  modport sink (input valid, blur_red, blur_green, blur_blue, frame_end, output ready);
endinterface

// File: hw/rtl/gaussian_blur_rgb_core.sv
// rgb gaussian blur over a line store of 9 rows of up to 1024 pixels.
// in_ch takes words in raster order: kind 0 is a pixel, kind 1 a drain that
// only releases the next pending output. out_ch gives at most one blurred
// pixel per input word, in raster order; frame_end marks the bottom right.
// cfg_we/cfg_index/cfg_data write radius, frame_width, frame_height and the
// five q2.16 weights; write them only while the block is idle.
// one word at a time: in_ch.ready is high only in the idle state. a pixel
// write passes through the row address unit (multiply, mod 9 by
// reciprocal, add). the blur walks the window row by row on one shared
// multiply-accumulate per channel and skips rows outside the frame; a drain
// that releases an output skips the store write. at radius 0 the stored
// pixel passes through unblurred.
// the result sits in an output register; the next word is taken while it
// waits, and a stalled receiver only holds the block when a second result
// is ready. reset clears counters and config to defaults; store contents
// stay undefined until written.
module gaussian_blur_rgb_core (
  input  logic clk,
  input  logic rst,
  gbr_in_if.sink    in_ch,
  gbr_out_if.source out_ch,
  input  logic                           cfg_we,
  input  logic [gbr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [gbr_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = gbr_pkg::ADDR_W;
  localparam int WW = gbr_pkg::WEIGHT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_B1    = 4'd1;
  localparam logic [3:0] S_B2    = 4'd2;
  localparam logic [3:0] S_B3    = 4'd3;
  localparam logic [3:0] S_WRITE = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_ROW   = 4'd6;
  localparam logic [3:0] S_COL   = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_RMUL  = 4'd9;
  localparam logic [3:0] S_RACC  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_PREAD = 4'd12;
  localparam logic [3:0] S_PWAIT = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  localparam logic [1:0] P_WRITE = 2'd0;
  localparam logic [1:0] P_BLUR  = 2'd1;
  localparam logic [1:0] P_PASS  = 2'd2;

  localparam logic [12:0] RECIP9_W = gbr_pkg::RECIP9;

  // config
  logic [2:0]    radius;
  logic [10:0]   frame_width;
  logic [12:0]   frame_height;
  logic [WW-1:0] weight [5];

  logic [3:0]  state;
  logic [1:0]  purpose;
  logic [11:0] in_row, out_row;
  logic [9:0]  in_col, out_col;
  logic        in_full;
  logic [23:0] px;

  logic [11:0] base_row;
  logic [21:0] prod;
  logic [8:0]  quot;
  logic [AW-1:0] base;

  logic signed [3:0] dy, dx;
  logic        v1;
  logic [WW-1:0] wx1;
  logic [23:0] q;
  logic [29:0] rsum [3];
  logic [47:0] rprod [3];
  logic [51:0] acc [3];
  logic [23:0] res;

  logic [23:0] store [gbr_pkg::STORE_DEPTH];

  // effective config
  logic [10:0] eff_w;
  logic [12:0] eff_h;
  logic [2:0]  eff_r;
  always_comb begin
    if (frame_width == 11'd0) eff_w = 11'd1;
    else if (frame_width > 11'(gbr_pkg::MAX_WIDTH)) eff_w = 11'(gbr_pkg::MAX_WIDTH);
    else eff_w = frame_width;
    if (frame_height == 13'd0) eff_h = 13'd1;
    else if (frame_height > 13'(gbr_pkg::MAX_HEIGHT)) eff_h = 13'(gbr_pkg::MAX_HEIGHT);
    else eff_h = frame_height;
    eff_r = (radius > 3'(gbr_pkg::MAX_RADIUS)) ? 3'(gbr_pkg::MAX_RADIUS) : radius;
  end

  // window position
  logic signed [13:0] row_s;
  logic signed [11:0] col_s;
  logic row_in, col_in;
  logic [2:0] abs_dx, abs_dy;
  logic signed [3:0] rad_s;
  always_comb begin
    rad_s  = $signed({1'b0, eff_r});
    row_s  = $signed({2'b00, out_row}) + 14'($signed(dy));
    col_s  = $signed({2'b00, out_col}) + 12'($signed(dx));
    row_in = !row_s[13] && (row_s[12:0] < eff_h);
    col_in = !col_s[11] && (col_s[10:0] < eff_w);
    abs_dx = dx[3] ? 3'(-dx) : dx[2:0];
    abs_dy = dy[3] ? 3'(-dy) : dy[2:0];
  end

  // store address: row base plus column, one wrap
  logic [9:0]  col_sel;
  logic [AW:0] addr_sum;
  logic [AW-1:0] addr;
  always_comb begin
    case (state)
      S_WRITE: col_sel = in_col;
      S_COL:   col_sel = col_s[9:0];
      default: col_sel = out_col;
    endcase
    addr_sum = {1'b0, base} + (AW+1)'(col_sel);
    if (addr_sum >= (AW+1)'(gbr_pkg::STORE_DEPTH))
      addr = AW'(addr_sum - (AW+1)'(gbr_pkg::STORE_DEPTH));
    else
      addr = addr_sum[AW-1:0];
  end

  // output release check
  logic [11:0] nr;
  logic [9:0]  nc;
  logic [12:0] nr_sum;
  logic [10:0] nc_sum;
  logic        rel;
  always_comb begin
    nr_sum = {1'b0, out_row} + 13'(eff_r);
    nc_sum = {1'b0, out_col} + 11'(eff_r);
    nr = (nr_sum > eff_h - 13'd1) ? 12'(eff_h - 13'd1) : nr_sum[11:0];
    nc = (nc_sum > eff_w - 11'd1) ? 10'(eff_w - 11'd1) : nc_sum[9:0];
    rel = in_full || (nr < in_row) || (nr == in_row && nc < in_col);
  end

  logic [3:0] rem9;
  assign rem9 = 4'(prod[21:10] - (12'(quot) * 12'd9));

  logic [24:0] recip_p;
  assign recip_p = prod[21:10] * RECIP9_W;

  function automatic logic [7:0] sat8(input logic [51:0] s);
    sat8 = (s[51:32] > 20'd255) ? 8'hff : s[39:32];
  endfunction

  assign in_ch.ready = (state == S_IDLE);

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= gbr_pkg::RADIUS_RST;
      frame_width  <= gbr_pkg::WIDTH_RST;
      frame_height <= gbr_pkg::HEIGHT_RST;
      weight[0]    <= gbr_pkg::WEIGHT0_RST;
      weight[1]    <= gbr_pkg::WEIGHT1_RST;
      weight[2]    <= '0;
      weight[3]    <= '0;
      weight[4]    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gbr_pkg::REG_RADIUS) radius <= cfg_data[2:0];
      else if (cfg_index == gbr_pkg::REG_WIDTH) frame_width <= cfg_data[10:0];
      else if (cfg_index == gbr_pkg::REG_HEIGHT) frame_height <= cfg_data[12:0];
      else weight[3'(cfg_index - gbr_pkg::REG_WEIGHT_0)] <= cfg_data[WW-1:0];
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (state == S_WRITE) store[addr] <= px;
    q <= store[addr];
  end

  // shared multiply-accumulate, one lane per channel
  always_ff @(posedge clk) begin
    v1  <= (state == S_COL) && col_in;
    wx1 <= weight[abs_dx];
    for (int i = 0; i < 3; i++) begin
      if (state == S_B3) rsum[i] <= '0;
      else if (v1) rsum[i] <= rsum[i] + 30'(wx1 * q[8*(2-i) +: 8]);
      if (state == S_RMUL) rprod[i] <= rsum[i] * weight[abs_dy];
      if (state == S_CHECK) acc[i] <= '0;
      else if (state == S_RACC) acc[i] <= acc[i] + 52'(rprod[i]);
    end
  end

  // row base unit and datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      px <= {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue};
    end
    if (state == S_IDLE) base_row <= in_row;
    else if (state == S_CHECK) base_row <= out_row;
    else if (state == S_ROW) base_row <= row_s[11:0];
    prod <= 22'(base_row * eff_w);
    quot <= recip_p[24:16];
    if (state == S_B3) base <= {rem9, prod[9:0]};
    if (state == S_FIN) res <= {sat8(acc[0]), sat8(acc[1]), sat8(acc[2])};
    else if (state == S_PWAIT) res <= q;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      purpose       <= P_WRITE;
      in_row        <= '0;
      in_col        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      in_full       <= 1'b0;
      dy            <= '0;
      dx            <= '0;
      out_ch.valid  <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_OUT) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.kind == 1'(gbr_pkg::KIND_PIXEL) && !in_full) begin
              purpose <= P_WRITE;
              state   <= S_B1;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_B1: state <= S_B2;
        S_B2: state <= S_B3;
        S_B3: begin
          case (purpose)
            P_WRITE: state <= S_WRITE;
            P_BLUR: begin
              dx    <= -rad_s;
              state <= S_COL;
            end
            default: state <= S_PREAD;
          endcase
        end
        S_WRITE: begin
          if (11'(in_col) + 11'd1 >= eff_w) begin
            in_col <= '0;
            if (13'(in_row) + 13'd1 >= eff_h) begin
              in_row  <= '0;
              in_full <= 1'b1;
            end else begin
              in_row <= in_row + 12'd1;
            end
          end else begin
            in_col <= in_col + 10'd1;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!rel) begin
            state <= S_IDLE;
          end else if (eff_r == 3'd0) begin
            purpose <= P_PASS;
            state   <= S_B1;
          end else begin
            dy    <= -rad_s;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (row_in) begin
            purpose <= P_BLUR;
            state   <= S_B1;
          end else if (dy == rad_s) begin
            state <= S_FIN;
          end else begin
            dy <= dy + 4'sd1;
          end
        end
        S_COL: begin
          if (dx == rad_s) state <= S_DRAIN;
          else dx <= dx + 4'sd1;
        end
        S_DRAIN: state <= S_RMUL;
        S_RMUL:  state <= S_RACC;
        S_RACC: begin
          if (dy == rad_s) begin
            state <= S_FIN;
          end else begin
            dy    <= dy + 4'sd1;
            state <= S_ROW;
          end
        end
        S_FIN:   state <= S_OUT;
        S_PREAD: state <= S_PWAIT;
        S_PWAIT: state <= S_OUT;
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid      <= 1'b1;
            out_ch.blur_red   <= res[23:16];
            out_ch.blur_green <= res[15:8];
            out_ch.blur_blue  <= res[7:0];
            out_ch.frame_end  <= (11'(out_col) + 11'd1 >= eff_w) &&
                                 (13'(out_row) + 13'd1 >= eff_h);
            if (11'(out_col) + 11'd1 >= eff_w) begin
              out_col <= '0;
              if (13'(out_row) + 13'd1 >= eff_h) begin
                out_row <= '0;
                in_full <= 1'b0;
              end else begin
                out_row <= out_row + 12'd1;
              end
            end else begin
              out_col <= out_col + 10'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: bench/gbr_blur_checker.sv
module gbr_blur_checker (
  input  logic                       clk,
  input  logic                       rst,
  gbr_in_if                          in_mon,
  gbr_out_if                         out_mon,
  input  logic                       cfg_we,
  input  logic [gbr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gbr_pkg::CFG_W-1:0]  cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         results,
  output logic                       frame_full
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [gbr_pkg::PIX_W-1:0] red;
    logic [gbr_pkg::PIX_W-1:0] green;
    logic [gbr_pkg::PIX_W-1:0] blue;
    logic                      last;
  } blur_word_t;

  blur_word_t                     blur_q[$];
  logic [gbr_pkg::RGB_W-1:0]      line_mem [gbr_pkg::STORE_DEPTH];
  logic [2:0]                     radius_r;
  logic [10:0]                    width_r;
  logic [12:0]                    height_r;
  logic [gbr_pkg::WEIGHT_W-1:0]   weight_r [5];
  int unsigned                    in_row, in_col, out_row, out_col;

  assign pending = blur_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results);
    errors++;
  endtask

  function automatic int unsigned line_addr(int unsigned r, int unsigned c, int unsigned w);
    longint unsigned a;
    a = longint'(r) * w + c;
    return int'(a % gbr_pkg::STORE_DEPTH);
  endfunction

  function automatic logic [gbr_pkg::PIX_W-1:0] clip8(longint unsigned s);
    longint unsigned v;
    v = s >> 32;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [gbr_pkg::RGB_W-1:0] blurred(int unsigned w, int unsigned h,
                                                         int unsigned rad);
    longint unsigned sr, sg, sb, k;
    logic [gbr_pkg::RGB_W-1:0] p;
    int r, c;
    sr = 0; sg = 0; sb = 0;
    if (rad == 0) return line_mem[line_addr(out_row, out_col, w)];
    for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
      r = int'(out_row) + dy;
      if (r < 0 || r >= int'(h)) continue;
      for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
        c = int'(out_col) + dx;
        if (c < 0 || c >= int'(w)) continue;
        k = longint'(weight_r[dy < 0 ? -dy : dy]) * longint'(weight_r[dx < 0 ? -dx : dx]);
        p = line_mem[line_addr(r, c, w)];
        sr += k * p[23:16];
        sg += k * p[15:8];
        sb += k * p[7:0];
      end
    end
    return {clip8(sr), clip8(sg), clip8(sb)};
  endfunction

  task automatic take_word(input logic kind, input logic [gbr_pkg::RGB_W-1:0] px);
    int unsigned w, h, rad, nr, nc;
    blur_word_t bw;
    w = (width_r == 0) ? 1 : (width_r > gbr_pkg::MAX_WIDTH) ? gbr_pkg::MAX_WIDTH : width_r;
    h = (height_r == 0) ? 1 :
        (height_r > gbr_pkg::MAX_HEIGHT) ? gbr_pkg::MAX_HEIGHT : height_r;
    rad = (radius_r > gbr_pkg::MAX_RADIUS) ? gbr_pkg::MAX_RADIUS : radius_r;
    if (kind == gbr_pkg::KIND_PIXEL && !frame_full) begin
      line_mem[line_addr(in_row, in_col, w)] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          frame_full = 1'b1;
        end
      end
    end
    if (!frame_full) begin
      nr = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
      nc = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
      if (!(nr < in_row || (nr == in_row && nc < in_col))) return;
    end
    {bw.red, bw.green, bw.blue} = blurred(w, h, rad);
    bw.last = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        out_row = 0;
        frame_full = 1'b0;
        bw.last = 1'b1;
      end
    end
    blur_q.push_back(bw);
  endtask

  always @(posedge clk) begin
    blur_word_t want;
    if (rst) begin
      radius_r = gbr_pkg::RADIUS_RST;
      width_r = gbr_pkg::WIDTH_RST;
      height_r = gbr_pkg::HEIGHT_RST;
      weight_r[0] = gbr_pkg::WEIGHT0_RST;
      weight_r[1] = gbr_pkg::WEIGHT1_RST;
      weight_r[2] = '0;
      weight_r[3] = '0;
      weight_r[4] = '0;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      frame_full = 1'b0;
      blur_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results++;
        if (blur_q.size() == 0) begin
          report("unexpected word", out_mon.blur_red, -1);
        end else begin
          want = blur_q.pop_front();
          if (out_mon.blur_red !== want.red) report("blur_red", out_mon.blur_red, want.red);
          if (out_mon.blur_green !== want.green)
            report("blur_green", out_mon.blur_green, want.green);
          if (out_mon.blur_blue !== want.blue) report("blur_blue", out_mon.blur_blue, want.blue);
          if (out_mon.frame_end !== want.last)
            report("frame_end", out_mon.frame_end, want.last);
        end
      end
      if (in_mon.valid && in_mon.ready)
        take_word(in_mon.kind, {in_mon.pixel_red, in_mon.pixel_green, in_mon.pixel_blue});
      if (cfg_we) begin
        if (cfg_index == gbr_pkg::REG_RADIUS) radius_r = cfg_data[2:0];
        else if (cfg_index == gbr_pkg::REG_WIDTH) width_r = cfg_data[10:0];
        else if (cfg_index == gbr_pkg::REG_HEIGHT) height_r = cfg_data[12:0];
        else weight_r[3'(cfg_index - gbr_pkg::REG_WEIGHT_0)] =
               cfg_data[gbr_pkg::WEIGHT_W-1:0];
      end
    end
  end
endmodule

// File: bench/gaussian_blur_rgb_core_tb.sv
module gaussian_blur_rgb_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [gbr_pkg::IDX_W-1:0] cfg_index;
  logic [gbr_pkg::CFG_W-1:0] cfg_data;
  int               errors, pending, results;
  logic             frame_full;
  int               src_idle, snk_idle, hold_cycles;
  int               words_sent, frames_run;

  gbr_in_if  in_ch ();
  gbr_out_if out_ch ();

  gaussian_blur_rgb_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gbr_blur_checker chk (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results(results), .frame_full(frame_full)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd200_000_000);
    $display("timeout with %0d words outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
      end
    end
  end

  task automatic send_word(input logic kind, input logic [gbr_pkg::RGB_W-1:0] px);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue} <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (words_sent == 420) begin
      src_idle = 57; snk_idle = 27;
    end else if (words_sent == 840) begin
      src_idle = 0; snk_idle = 0;
    end
  endtask

  task automatic write_config(input logic [2:0] rad, input logic [10:0] w,
                              input logic [12:0] h,
                              input logic [gbr_pkg::WEIGHT_W-1:0] wt [5]);
    logic [gbr_pkg::CFG_W-1:0] vals [8];
    vals[0] = gbr_pkg::CFG_W'(rad);
    vals[1] = gbr_pkg::CFG_W'(w);
    vals[2] = gbr_pkg::CFG_W'(h);
    for (int i = 0; i < 5; i++) vals[3 + i] = wt[i];
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i == 0) ? gbr_pkg::REG_RADIUS : (i == 1) ? gbr_pkg::REG_WIDTH :
                   (i == 2) ? gbr_pkg::REG_HEIGHT :
                   gbr_pkg::REG_WEIGHT_0 + gbr_pkg::IDX_W'(i - 3);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [gbr_pkg::RGB_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return gbr_pkg::RGB_W'($urandom);
    endcase
  endfunction

  // one frame: configure while idle, stream its pixels, drain to frame end
  task automatic blur_frame(input logic [2:0] rad, input logic [10:0] w, input logic [12:0] h,
                            input logic [gbr_pkg::WEIGHT_W-1:0] wt [5],
                            input bit extra_pixel);
    int unsigned n;
    n = ((w == 0) ? 1 : (w > gbr_pkg::MAX_WIDTH) ? gbr_pkg::MAX_WIDTH : w) *
        ((h == 0) ? 1 : h);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (200) @(negedge clk);
    write_config(rad, w, h, wt);
    for (int unsigned i = 0; i < n; i++) send_word(1'b0, rand_pixel());
    // a pixel arriving after the frame is complete is dropped
    if (extra_pixel && frame_full) send_word(1'b0, rand_pixel());
    while (frame_full) send_word(1'b1, gbr_pkg::RGB_W'($urandom));
    frames_run++;
  endtask

  initial begin
    logic [gbr_pkg::WEIGHT_W-1:0] wt [5];
    int unsigned base;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.pixel_red = '0;
    in_ch.pixel_green = '0;
    in_ch.pixel_blue = '0;
    hold_cycles = 0;
    src_idle = 27;
    snk_idle = 57;
    words_sent = 0;
    frames_run = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: unit centre weight, saturating weights, passthrough, clamped config
    wt = '{18'd65536, 18'd16384, 18'd0, 18'd0, 18'd0};
    blur_frame(3'd1, 11'd4, 13'd3, wt, 1'b1);
    wt = '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'd0, 18'd0};
    blur_frame(3'd2, 11'd5, 13'd1, wt, 1'b0);
    wt = '{18'd0, 18'd0, 18'd0, 18'd0, 18'd0};
    blur_frame(3'd0, 11'd3, 13'd2, wt, 1'b0);
    wt = '{18'd1, 18'd2, 18'd3, 18'd4, 18'd5};
    blur_frame(3'd7, 11'd0, 13'd0, wt, 1'b1);

    while (words_sent < 250) begin
      base = $urandom_range(20000, 70000);
      for (int i = 0; i < 5; i++)
        wt[i] = ($urandom_range(0, 4) == 0) ? gbr_pkg::WEIGHT_W'($urandom)
                : gbr_pkg::WEIGHT_W'(base >> (2 * i + $urandom_range(0, 2)));
      if (frames_run == 6) begin
        hold_cycles = 3000;
        blur_frame(3'd1, 11'd10, 13'd6, wt, 1'b0);
      end else begin
        blur_frame(3'($urandom_range(0, 7)), 11'($urandom_range(0, 12)),
                   13'($urandom_range(0, 8)), wt, $urandom_range(0, 3) == 0);
      end
    end

    // widest row
    wt = '{18'd40000, 18'd9000, 18'd3000, 18'd800, 18'd100};
    blur_frame(3'd4, 11'h7FF, 13'd1, wt, 1'b0);

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
    $display("%0d frames, %0d input words, %0d blurred words checked", frames_run,
             words_sent, results);
    $display("radius 0 to 7, widths 0 to 2047, heights 0 to 8, long output stall");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/gbr_pkg.sv
hw/rtl/gbr_in_if.sv
hw/rtl/gbr_out_if.sv
hw/rtl/gaussian_blur_rgb_core.sv
bench/gbr_blur_checker.sv
bench/gaussian_blur_rgb_core_tb.sv
